FILE: src/rars_pkg.sv
package rars_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_SECOND,
    ST_UPD_A,
    ST_UPD_B
  } step_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE_RD,
    S_PRE_ACC,
    S_PRE_MUL,
    S_PRE_END,
    S_UPD_MUL,
    S_UPD_RD,
    S_UPD_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         first_index;
    logic [9:0]         last_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] range_sum;
    logic               range_error;
  } out_item_t;

endpackage

FILE: src/rars_ram.sv
module rars_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/range_add_range_sum_tree.sv
// channel   direction  handshake                 payload
// item      in         item_valid / item_stall   item (op, first_index, last_index, value)
// result    out        result_valid / result_stall  result (range_sum, range_error)
// cfg       in         cfg_valid / cfg_ready     cfg_data (entries_in_use)
//
// walks: a query is two prefix walks, an add two update walks, a set both; each walk
//   visits at most L = clog2(MAX_ENTRIES+1) nodes, each node read, then accumulated
//   or written back
// reset: a clearing pass writes zero to every memory entry, item_stall high
//   meanwhile; config writes are taken at all times
// stalls: a query result waits in the output register; the next item is taken
//   while it waits, and only a second query holds at its end until it is free
module range_add_range_sum_tree #(
  parameter int unsigned MAX_ENTRIES = rars_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  rars_pkg::in_item_t             item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output rars_pkg::out_item_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rars_pkg::CFG_W-1:0]     cfg_data
);
  import rars_pkg::*;

  // two fenwick trees over positions 1..N: prefix(P) = S1(P)*P - S2(P)
  localparam int unsigned DEPTH = MAX_ENTRIES + 1;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 2;
  localparam logic [31:0] MAX32 = 32'(MAX_ENTRIES);
  localparam logic [PW-1:0] NPOS = PW'(MAX_ENTRIES);

  state_t state, state_next;
  step_t  step;
  logic [CFG_W-1:0] entries;
  logic [1:0]  op;
  logic [9:0]  a, b;
  logic [63:0] val;
  logic [PW-1:0] p, pref_pos, k;
  logic [AW-1:0] clr;
  logic [63:0] acc1, acc2, prod, s_save, d1, d2;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0] w1, w2, r1, r2;

  logic [31:0] count, a32, b32;
  logic        bad, set_ok;
  logic [PW-1:0] lowbit;
  logic [63:0] pre;
  logic        out_free;

  rars_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_sum1 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(w1), .raddr(ram_raddr), .rdata(r1)
  );
  rars_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_sum2 (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(w2), .raddr(ram_raddr), .rdata(r2)
  );

  assign cfg_ready = 1'b1;

  // limit checks on the incoming item
  assign count  = ({21'd0, entries} > MAX32) ? MAX32 : {21'd0, entries};
  assign a32    = {22'd0, item.first_index};
  assign b32    = {22'd0, item.last_index};
  assign bad    = (a32 > b32) || (b32 >= count);
  assign set_ok = a32 < count;

  assign lowbit   = p & (~p + PW'(1));
  assign pre      = prod - acc2;
  assign out_free = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:   if (clr == AW'(DEPTH - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (item_valid) begin
          unique case (item.op)
            OP_SET:   state_next = set_ok ? S_PRE_RD : S_IDLE;
            OP_ADD:   state_next = bad ? S_IDLE : S_UPD_MUL;
            OP_QUERY: state_next = bad ? S_DONE : S_PRE_RD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_PRE_RD:  state_next = (p == '0) ? S_PRE_MUL : S_PRE_ACC;
      S_PRE_ACC: state_next = S_PRE_RD;
      S_PRE_MUL: state_next = S_PRE_END;
      S_PRE_END: begin
        if (step == ST_FIRST) state_next = S_PRE_RD;
        else if (op == OP_QUERY) state_next = S_DONE;
        else state_next = S_UPD_MUL;
      end
      S_UPD_MUL: state_next = S_UPD_RD;
      S_UPD_RD: begin
        if (p > NPOS) state_next = (step == ST_UPD_A) ? S_UPD_MUL : S_IDLE;
        else state_next = S_UPD_WR;
      end
      S_UPD_WR:  state_next = S_UPD_RD;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    item_stall = (state != S_IDLE);
    ram_raddr  = p[AW-1:0];
    ram_we     = 1'b0;
    ram_waddr  = p[AW-1:0];
    w1         = r1 + d1;
    w2         = r2 + d2;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        w1        = '0;
        w2        = '0;
      end
      S_UPD_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr     <= '0;
      entries <= ENTRIES_RESET;
      step    <= ST_FIRST;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) entries <= cfg_data;
      // in done the result register is reloaded below when it frees up
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr <= clr + AW'(1);
        S_IDLE: begin
          if (item_valid) begin
            op   <= item.op;
            a    <= item.first_index;
            b    <= item.last_index;
            val  <= {{32{item.value[31]}}, item.value};
            acc1 <= '0;
            acc2 <= '0;
            unique case (item.op)
              OP_SET: begin
                step <= ST_FIRST;
                p <= PW'(item.first_index) + PW'(1);
                pref_pos <= PW'(item.first_index) + PW'(1);
              end
              OP_ADD: begin
                step <= ST_UPD_A;
                d1 <= {{32{item.value[31]}}, item.value};
                k  <= PW'(item.first_index);
                p  <= PW'(item.first_index) + PW'(1);
              end
              OP_QUERY: begin
                step <= ST_FIRST;
                p <= PW'(item.last_index) + PW'(1);
                pref_pos <= PW'(item.last_index) + PW'(1);
              end
              default: step <= ST_FIRST;
            endcase
          end
        end
        S_PRE_ACC: begin
          acc1 <= acc1 + r1;
          acc2 <= acc2 + r2;
          p    <= p - lowbit;
        end
        S_PRE_MUL: prod <= acc1 * {{(64-PW){1'b0}}, pref_pos};
        S_PRE_END: begin
          if (step == ST_FIRST) begin
            // second prefix ends just before the first entry
            s_save   <= pre;
            step     <= ST_SECOND;
            acc1     <= '0;
            acc2     <= '0;
            p        <= PW'(a);
            pref_pos <= PW'(a);
          end else if (op == OP_QUERY) begin
            s_save <= s_save - pre;
          end else begin
            // set becomes a point add of new minus old
            step <= ST_UPD_A;
            d1   <= val - (s_save - pre);
            k    <= PW'(a);
            p    <= PW'(a) + PW'(1);
          end
        end
        S_UPD_MUL: d2 <= d1 * {{(64-PW){1'b0}}, k};
        S_UPD_RD: begin
          if (p > NPOS && step == ST_UPD_A) begin
            // closing edge of the range, one past its last entry
            step <= ST_UPD_B;
            d1   <= ~d1 + 64'd1;
            k    <= (op == OP_SET) ? PW'(a) + PW'(1) : PW'(b) + PW'(1);
            p    <= (op == OP_SET) ? PW'(a) + PW'(2) : PW'(b) + PW'(2);
          end
        end
        S_UPD_WR: p <= p + lowbit;
        S_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            result.range_error <= (step == ST_FIRST);
            result.range_sum   <= (step == ST_FIRST) ? 64'sd0 : s_save;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> item_stall)
    else $error("item taken during clearing pass");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside done");
  a_acc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRE_ACC) |-> $past(p) != '0)
    else $error("prefix walk read position zero");
`endif

endmodule
